// ===== rtl/lpp_pkg.sv =====
// Shared types, constants and fixed-point helpers of the lidar point projector.
package lpp_pkg;

  // Fixed-point format of every coordinate and coefficient
  localparam int FRAC_BITS = 16;

  // Coefficient store layout
  localparam int NUM_COEF = 18;
  localparam int NUM_MAT  = 12;
  localparam int IDX_FX   = 12;
  localparam int IDX_FY   = 13;
  localparam int IDX_CX   = 14;
  localparam int IDX_CY   = 15;
  localparam int IDX_K1   = 16;
  localparam int IDX_K2   = 17;

  // Divider geometry: quotient bits below the sign, working width
  localparam int DIV_QB  = 31;
  localparam int DIV_W   = 96;
  localparam int DIV_LAT = DIV_QB + 2;
  // Register stages of the distortion datapath
  localparam int DST_LAT = 10;

  // Configuration register indexes
  localparam logic [1:0] REG_MAX_ABS_X    = 2'd0;
  localparam logic [1:0] REG_MAX_ABS_Y    = 2'd1;
  localparam logic [1:0] REG_MIN_HEIGHT_Z = 2'd2;

  // Reset values of the gate limits
  localparam logic [30:0]        RST_MAX_ABS_X    = 31'd6553600;
  localparam logic [30:0]        RST_MAX_ABS_Y    = 31'd6553600;
  localparam logic signed [31:0] RST_MIN_HEIGHT_Z = -32'sd131072;

  // Intensity color map constants
  localparam logic [7:0]  COLOR_MID   = 8'd128;
  localparam logic [15:0] COLOR_SCALE = 16'd255;

  typedef logic signed [31:0] q_t;
  typedef logic signed [63:0] w_t;
  typedef q_t [NUM_MAT-1:0]   mat_t;

  localparam q_t Q_MAX  = 32'sh7FFF_FFFF;
  localparam q_t Q_MIN  = 32'sh8000_0000;
  localparam w_t W_ONE  = w_t'(1) <<< FRAC_BITS;
  localparam w_t W_HALF = w_t'(1) <<< (FRAC_BITS - 1);

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_POINT = 1'b1
  } op_e;

  typedef struct packed {
    logic [30:0]        max_abs_x;
    logic [30:0]        max_abs_y;
    logic signed [31:0] min_height_z;
  } gate_cfg_t;

  typedef struct packed {
    q_t k1;
    q_t k2;
    q_t fx;
    q_t fy;
    q_t cx;
    q_t cy;
  } dst_coef_t;

  // Exact signed product of two words
  function automatic w_t mul_full(input q_t a, input q_t b);
    w_t aw;
    w_t bw;
    aw = w_t'(a);
    bw = w_t'(b);
    return aw * bw;
  endfunction

  // Round a product to FRAC_BITS fraction bits: add one half, floor
  function automatic w_t round_q(input w_t p);
    return (p + W_HALF) >>> FRAC_BITS;
  endfunction

  // Clamp to the signed 32-bit range
  function automatic q_t sat32(input w_t v);
    if (v > w_t'(Q_MAX)) begin
      return Q_MAX;
    end else if (v < w_t'(Q_MIN)) begin
      return Q_MIN;
    end
    return v[31:0];
  endfunction

endpackage

// ===== rtl/lpp_if.sv =====
// Channel interfaces: point input, pixel result and configuration write.
interface lpp_in_if;
  import lpp_pkg::*;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [4:0] coef_index;
  q_t         coef_value;
  q_t         point_x;
  q_t         point_y;
  q_t         point_z;
  logic [7:0] intensity;
  modport source (output valid, opcode, coef_index, coef_value, point_x, point_y, point_z,
                  intensity, input ready);
  modport sink   (input valid, opcode, coef_index, coef_value, point_x, point_y, point_z,
                  intensity, output ready);
endinterface

interface lpp_out_if;
  import lpp_pkg::*;
  logic       valid;
  logic       ready;
  q_t         pixel_u;
  q_t         pixel_v;
  logic [7:0] red;
  logic [7:0] green;
  modport source (output valid, pixel_u, pixel_v, red, green, input ready);
  modport sink   (input valid, pixel_u, pixel_v, red, green, output ready);
endinterface

interface lpp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/lidar_point_to_pixel_projector_unit.sv =====
// Top level of the lidar point to pixel projector.
//
// in_i carries coefficient loads (opcode 0) and lidar points (opcode 1).
// A load writes one of the 18 coefficient words at its transfer and gives
// no result; load every coefficient before sending points. A point is
// range gated, transformed by the 3x4 matrix, divided by its camera depth,
// normalized, radially distorted and rescaled; out_o returns the pixel
// position with red/green colors. Gated points and a zero camera depth
// give no result. cfg_i writes the gate limits, ready always; write it
// only while no point is in flight.
// Throughput: one item per cycle while out_o is not stalled. A point
// passes the matrix stages, the two chained dividers (one quotient bit
// per stage), the distortion multipliers and the output register on its
// way to out_o.valid.
// Reset clears all valid bits and restores the gate limits; the
// coefficient store is not cleared. When the receiver stalls, the whole
// pipeline holds and in_i.ready falls; nothing is dropped or repeated.
module lidar_point_to_pixel_projector_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  lpp_in_if.sink     in_i,
  lpp_out_if.source  out_o,
  lpp_cfg_if.sink    cfg_i
);
  import lpp_pkg::*;

  localparam int LINE_LEN = 2 * DIV_LAT + DST_LAT;

  q_t         coef_q [NUM_COEF];
  gate_cfg_t  gate_q;
  mat_t       mat;
  dst_coef_t  dcoef;

  logic       en, in_xfer;
  logic       xf_v;
  w_t         cam0, cam1, cam2;
  logic [7:0] xf_red, xf_green;
  q_t         u_div, v_div, xn, yn, pu, pv;

  logic       line_v_q [LINE_LEN];
  logic [7:0] line_r_q [LINE_LEN];
  logic [7:0] line_g_q [LINE_LEN];

  logic       out_v_q;
  q_t         out_u_q, out_pv_q;
  logic [7:0] out_r_q, out_g_q;

  // Advance everything unless a result waits
  assign en          = !out_v_q || out_o.ready;
  assign in_i.ready  = en;
  assign in_xfer     = in_i.valid && en;
  assign cfg_i.ready = 1'b1;

  // Coefficient store
  always_ff @(posedge clk_i) begin
    if (in_xfer && (in_i.opcode == OP_LOAD) && (in_i.coef_index < 5'(NUM_COEF))) begin
      coef_q[in_i.coef_index] <= in_i.coef_value;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_MAT; i++) begin
      mat[i] = coef_q[i];
    end
    dcoef.k1 = coef_q[IDX_K1];
    dcoef.k2 = coef_q[IDX_K2];
    dcoef.fx = coef_q[IDX_FX];
    dcoef.fy = coef_q[IDX_FY];
    dcoef.cx = coef_q[IDX_CX];
    dcoef.cy = coef_q[IDX_CY];
  end

  // Gate limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q.max_abs_x    <= RST_MAX_ABS_X;
      gate_q.max_abs_y    <= RST_MAX_ABS_Y;
      gate_q.min_height_z <= RST_MIN_HEIGHT_Z;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_MAX_ABS_X:    gate_q.max_abs_x    <= cfg_i.data[30:0];
        REG_MAX_ABS_Y:    gate_q.max_abs_y    <= cfg_i.data[30:0];
        REG_MIN_HEIGHT_Z: gate_q.min_height_z <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  lpp_xform u_xform (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in_xfer && (in_i.opcode == OP_POINT)),
    .x_i         (in_i.point_x),
    .y_i         (in_i.point_y),
    .z_i         (in_i.point_z),
    .intensity_i (in_i.intensity),
    .mat_i       (mat),
    .gate_i      (gate_q),
    .valid_o     (xf_v),
    .cam0_o      (cam0),
    .cam1_o      (cam1),
    .cam2_o      (cam2),
    .red_o       (xf_red),
    .green_o     (xf_green)
  );

  // Perspective divide
  lpp_div u_div_u (.clk_i(clk_i), .en_i(en), .num_i(cam0), .den_i(cam2), .quo_o(u_div));
  lpp_div u_div_v (.clk_i(clk_i), .en_i(en), .num_i(cam1), .den_i(cam2), .quo_o(v_div));

  // Normalize about the principal point
  lpp_div u_div_xn (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (w_t'(u_div) - w_t'(dcoef.cx)),
    .den_i (w_t'(dcoef.fx)),
    .quo_o (xn)
  );
  lpp_div u_div_yn (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (w_t'(v_div) - w_t'(dcoef.cy)),
    .den_i (w_t'(dcoef.fy)),
    .quo_o (yn)
  );

  lpp_distort u_distort (
    .clk_i  (clk_i),
    .en_i   (en),
    .xn_i   (xn),
    .yn_i   (yn),
    .coef_i (dcoef),
    .pu_o   (pu),
    .pv_o   (pv)
  );

  // Valid and colors ride alongside the dividers and distortion; drop zero depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LINE_LEN; i++) begin
        line_v_q[i] <= 1'b0;
      end
    end else if (en) begin
      line_v_q[0] <= xf_v && (cam2 != '0);
      for (int i = 1; i < LINE_LEN; i++) begin
        line_v_q[i] <= line_v_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      line_r_q[0] <= xf_red;
      line_g_q[0] <= xf_green;
      for (int i = 1; i < LINE_LEN; i++) begin
        line_r_q[i] <= line_r_q[i-1];
        line_g_q[i] <= line_g_q[i-1];
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= line_v_q[LINE_LEN-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_u_q  <= pu;
      out_pv_q <= pv;
      out_r_q  <= line_r_q[LINE_LEN-1];
      out_g_q  <= line_g_q[LINE_LEN-1];
    end
  end

  assign out_o.valid   = out_v_q;
  assign out_o.pixel_u = out_u_q;
  assign out_o.pixel_v = out_pv_q;
  assign out_o.red     = out_r_q;
  assign out_o.green   = out_g_q;

  // A zero camera depth never enters the divider pipeline as valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && xf_v && (cam2 == '0) |=> !line_v_q[0])
    else $error("zero-depth point entered divider pipeline");

  // A stall freezes the head and the tail of the valid line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(line_v_q[LINE_LEN-1]) && $stable(line_v_q[0]))
    else $error("pipeline moved during stall");

  // A finished point reaches the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && line_v_q[LINE_LEN-1] |=> out_v_q)
    else $error("result lost at output register");

endmodule

// ===== rtl/lpp_xform.sv =====
// Range gate, 3x4 matrix transform and intensity color map.
module lpp_xform (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  lpp_pkg::q_t        x_i,
  input  lpp_pkg::q_t        y_i,
  input  lpp_pkg::q_t        z_i,
  input  logic [7:0]         intensity_i,
  input  lpp_pkg::mat_t      mat_i,
  input  lpp_pkg::gate_cfg_t gate_i,
  output logic               valid_o,
  output lpp_pkg::w_t        cam0_o,
  output lpp_pkg::w_t        cam1_o,
  output lpp_pkg::w_t        cam2_o,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o
);
  import lpp_pkg::*;

  logic       v1_q, v2_q, v3_q;
  q_t         x1_q, y1_q, z1_q;
  logic [7:0] int1_q;
  logic [7:0] red2_q, green2_q, red3_q, green3_q;
  w_t         prod2_q [9];
  w_t         cam3_q [3];

  logic [31:0] ax, ay;
  logic        gate_ok;
  logic [7:0]  ofs;
  logic [15:0] red_w, green_w;

  // Gate test and color map on the registered point
  always_comb begin
    ax      = x1_q[31] ? 32'(-x1_q) : x1_q;
    ay      = y1_q[31] ? 32'(-y1_q) : y1_q;
    gate_ok = (ax <= {1'b0, gate_i.max_abs_x}) && (ay <= {1'b0, gate_i.max_abs_y}) &&
              (z1_q >= gate_i.min_height_z);
    ofs     = (int1_q >= COLOR_MID) ? (int1_q - COLOR_MID) : (COLOR_MID - int1_q);
    red_w   = (16'(ofs) * COLOR_SCALE) >> 7;
    green_w = (16'(COLOR_MID - ofs) * COLOR_SCALE) >> 7;
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q && gate_ok;
      v3_q <= v2_q;
    end
  end

  // Capture, multiply, then round and sum each row
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q     <= x_i;
      y1_q     <= y_i;
      z1_q     <= z_i;
      int1_q   <= intensity_i;
      red2_q   <= red_w[7:0];
      green2_q <= green_w[7:0];
      for (int r = 0; r < 3; r++) begin
        prod2_q[r*3]     <= mul_full(mat_i[r*4],     x1_q);
        prod2_q[r*3 + 1] <= mul_full(mat_i[r*4 + 1], y1_q);
        prod2_q[r*3 + 2] <= mul_full(mat_i[r*4 + 2], z1_q);
        cam3_q[r] <= round_q(prod2_q[r*3]) + round_q(prod2_q[r*3 + 1]) +
                     round_q(prod2_q[r*3 + 2]) + w_t'(mat_i[r*4 + 3]);
      end
      red3_q   <= red2_q;
      green3_q <= green2_q;
    end
  end

  assign valid_o = v3_q;
  assign cam0_o  = cam3_q[0];
  assign cam1_o  = cam3_q[1];
  assign cam2_o  = cam3_q[2];
  assign red_o   = red3_q;
  assign green_o = green3_q;

endmodule

// ===== rtl/lpp_div.sv =====
// Pipelined fixed-point divider, one quotient bit per stage, saturating.
module lpp_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  lpp_pkg::w_t num_i,
  input  lpp_pkg::w_t den_i,
  output lpp_pkg::q_t quo_o
);
  import lpp_pkg::*;

  logic [DIV_W-1:0]  rem_q  [DIV_QB+1];
  logic [63:0]       den_q  [DIV_QB+1];
  logic [DIV_QB-1:0] bits_q [DIV_QB+1];
  logic              neg_q  [DIV_QB+1];
  logic              spec_q [DIV_QB+1];
  q_t                fix_q  [DIV_QB+1];
  q_t                quo_q;

  logic [63:0] a, b;
  logic        neg, zden, ovf;
  q_t          fix;

  // Magnitudes, sign and the saturating cases
  always_comb begin
    a    = num_i[63] ? 64'(-num_i) : num_i;
    b    = den_i[63] ? 64'(-den_i) : den_i;
    neg  = num_i[63] ^ den_i[63];
    zden = (den_i == '0);
    ovf  = ({32'd0, a} >= ({32'd0, b} << (DIV_QB - FRAC_BITS)));
    if (zden) begin
      if (num_i > 0) begin
        fix = Q_MAX;
      end else if (num_i < 0) begin
        fix = Q_MIN;
      end else begin
        fix = '0;
      end
    end else begin
      fix = neg ? Q_MIN : Q_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= {32'd0, a} << FRAC_BITS;
      den_q[0]  <= b;
      bits_q[0] <= '0;
      neg_q[0]  <= neg;
      spec_q[0] <= zden || ovf;
      fix_q[0]  <= fix;
    end
  end

  // One restoring step per stage, most significant bit first
  for (genvar k = 0; k < DIV_QB; k++) begin : g_step
    localparam int BIT = DIV_QB - 1 - k;
    logic [DIV_W-1:0]  sh;
    logic              ge;
    logic [DIV_QB-1:0] bn;
    always_comb begin
      sh      = {32'd0, den_q[k]} << BIT;
      ge      = (rem_q[k] >= sh);
      bn      = bits_q[k];
      bn[BIT] = ge;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? (rem_q[k] - sh) : rem_q[k];
        den_q[k+1]  <= den_q[k];
        bits_q[k+1] <= bn;
        neg_q[k+1]  <= neg_q[k];
        spec_q[k+1] <= spec_q[k];
        fix_q[k+1]  <= fix_q[k];
      end
    end
  end

  // Apply the sign or the saturated value
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (spec_q[DIV_QB]) begin
        quo_q <= fix_q[DIV_QB];
      end else if (neg_q[DIV_QB]) begin
        quo_q <= -q_t'({1'b0, bits_q[DIV_QB]});
      end else begin
        quo_q <= q_t'({1'b0, bits_q[DIV_QB]});
      end
    end
  end

  assign quo_o = quo_q;

endmodule

// ===== rtl/lpp_distort.sv =====
// Radial k1/k2 distortion and rescale to pixel coordinates.
module lpp_distort (
  input  logic               clk_i,
  input  logic               en_i,
  input  lpp_pkg::q_t        xn_i,
  input  lpp_pkg::q_t        yn_i,
  input  lpp_pkg::dst_coef_t coef_i,
  output lpp_pkg::q_t        pu_o,
  output lpp_pkg::q_t        pv_o
);
  import lpp_pkg::*;

  q_t xn_q [6];
  q_t yn_q [6];
  w_t pxx_q, pyy_q, prr_q, pk1_q, pk2_q, pu_q, pv_q, pfu_q, pfv_q;
  w_t k1r2_q, k1r2d_q;
  q_t r2_q, r4_q, fac_q, du_q, dv_q, ou_q, ov_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // carry the normalized coordinates up to the factor multiply
      xn_q[0] <= xn_i;
      yn_q[0] <= yn_i;
      for (int i = 1; i < 6; i++) begin
        xn_q[i] <= xn_q[i-1];
        yn_q[i] <= yn_q[i-1];
      end
      // squared radius
      pxx_q   <= mul_full(xn_i, xn_i);
      pyy_q   <= mul_full(yn_i, yn_i);
      r2_q    <= sat32(round_q(pxx_q) + round_q(pyy_q));
      // fourth power and k1 term
      prr_q   <= mul_full(r2_q, r2_q);
      pk1_q   <= mul_full(coef_i.k1, r2_q);
      r4_q    <= sat32(round_q(prr_q));
      k1r2_q  <= round_q(pk1_q);
      // k2 term and distortion factor
      pk2_q   <= mul_full(coef_i.k2, r4_q);
      k1r2d_q <= k1r2_q;
      fac_q   <= sat32(W_ONE + k1r2d_q + round_q(pk2_q));
      // distorted normalized coordinate
      pu_q    <= mul_full(xn_q[5], fac_q);
      pv_q    <= mul_full(yn_q[5], fac_q);
      du_q    <= sat32(round_q(pu_q));
      dv_q    <= sat32(round_q(pv_q));
      // back to pixels
      pfu_q   <= mul_full(du_q, coef_i.fx);
      pfv_q   <= mul_full(dv_q, coef_i.fy);
      ou_q    <= sat32(round_q(pfu_q) + w_t'(coef_i.cx));
      ov_q    <= sat32(round_q(pfv_q) + w_t'(coef_i.cy));
    end
  end

  assign pu_o = ou_q;
  assign pv_o = ov_q;

endmodule
